// ===== rtl/egcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared width constants, state types and the status struct of the GCD unit.
// ----------------------------------------------------------------------------
package egcd_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    typedef logic [WIDTH-1:0] t_word;

    typedef enum logic {
        REM_IDLE,
        REM_RUN
    } t_rem_state;

    typedef enum logic [1:0] {
        GCD_IDLE,
        GCD_CHECK,
        GCD_WAIT
    } t_gcd_state;

    typedef struct packed {
        logic active;
        logic done;
    } t_rem_status;

endpackage

// ===== rtl/euclid_gcd_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclid_gcd_unit
// Greatest common divisor of two unsigned words by Euclid's remainder method.
// ----------------------------------------------------------------------------
// Usage: drive i_first_value and i_second_value and raise start while busy is
// low; the operands are taken at that edge and busy rises on the next cycle.
// The result appears on o_divisor for exactly one cycle with o_valid high,
// and busy is low in that same cycle, so a new transaction may start then.
// gcd(a,0) is a and gcd(0,0) is 0.
// Timing: each Euclid step costs one compare in the CHECK state plus a full
// pass of the bit-serial remainder unit; a step where the first operand is
// smaller is a plain swap without the remainder unit. When the second
// operand is zero no step is run and the result follows the CHECK state.
// The single shared remainder subtractor sets the run time.
// Reset returns the sequencer to idle and drops any transaction in flight.
// The receiver cannot stall; the result is simply presented for one cycle.
// ----------------------------------------------------------------------------
module euclid_gcd_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  egcd_pkg::t_word i_first_value,
    input  egcd_pkg::t_word i_second_value,
    output logic            o_valid,
    output egcd_pkg::t_word o_divisor
);
    import egcd_pkg::*;

    t_gcd_state  r_state, n_state;
    t_word       r_a;
    t_word       r_b;
    t_word       r_div;
    logic        r_valid;

    logic        accept;
    logic        finish;
    logic        swap;
    logic        rem_start;
    logic        rem_take;
    t_word       rem_val;
    t_rem_status rem_stat;

    egcd_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_rem      (rem_val),
        .o_status   (rem_stat)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            GCD_IDLE: begin
                if (start) begin
                    n_state = GCD_CHECK;
                end
            end
            GCD_CHECK: begin
                if (r_b == '0) begin
                    n_state = GCD_IDLE;
                end else if (r_a >= r_b) begin
                    n_state = GCD_WAIT;
                end
            end
            GCD_WAIT: begin
                if (rem_stat.done) begin
                    n_state = GCD_CHECK;
                end
            end
            default: n_state = GCD_IDLE;
        endcase
    end

    // When the first operand is the smaller, its remainder is itself, so
    // the step reduces to a swap without using the remainder unit.
    always_comb begin
        busy      = 1'b1;
        accept    = 1'b0;
        finish    = 1'b0;
        swap      = 1'b0;
        rem_start = 1'b0;
        rem_take  = 1'b0;
        case (r_state)
            GCD_IDLE: begin
                busy   = 1'b0;
                accept = start;
            end
            GCD_CHECK: begin
                finish    = (r_b == '0);
                swap      = (r_b != '0) && (r_a < r_b);
                rem_start = (r_b != '0) && (r_a >= r_b);
            end
            GCD_WAIT: rem_take = rem_stat.done;
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= GCD_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= i_first_value;
            r_b <= i_second_value;
        end else if (swap || rem_take) begin
            r_a <= r_b;
            r_b <= swap ? r_a : rem_val;
        end
        if (finish) begin
            r_div <= r_a;
        end
    end

    assign o_valid   = r_valid;
    assign o_divisor = r_div;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted transaction");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result presented while the sequencer is busy");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe lasted more than one cycle");

    a_rem_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rem_stat.active || rem_stat.done) |-> (r_state == GCD_WAIT))
        else $error("remainder unit active outside the wait state");

    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_start |-> (r_b != '0))
        else $error("remainder started with a zero divisor");

endmodule

// ===== rtl/egcd_rem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_rem
// Iterative restoring remainder unit: one dividend bit per cycle through a
// single shared subtractor, over all WIDTH bits of the dividend.
// ----------------------------------------------------------------------------
module egcd_rem (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  egcd_pkg::t_word      i_dividend,
    input  egcd_pkg::t_word      i_divisor,
    output egcd_pkg::t_word      o_rem,
    output egcd_pkg::t_rem_status o_status
);
    import egcd_pkg::*;

    t_rem_state       r_state, n_state;
    t_word            r_dvd;
    t_word            r_dsr;
    t_word            r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic             load;
    logic             step;
    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   diff;
    t_word            rem_next;

    // The partial remainder stays below the divisor, so the shifted value
    // is below twice the divisor and one conditional subtract suffices.
    always_comb begin
        rem_sh   = {r_rem, r_dvd[WIDTH-1]};
        diff     = rem_sh - {1'b0, r_dsr};
        rem_next = diff[WIDTH] ? rem_sh[WIDTH-1:0] : diff[WIDTH-1:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            REM_IDLE: begin
                if (i_start) begin
                    n_state = REM_RUN;
                end
            end
            REM_RUN: begin
                if (r_cnt == '0) begin
                    n_state = REM_IDLE;
                end
            end
            default: n_state = REM_IDLE;
        endcase
    end

    always_comb begin
        load = 1'b0;
        step = 1'b0;
        case (r_state)
            REM_IDLE: load = i_start;
            REM_RUN:  step = 1'b1;
            default: begin
                load = 1'b0;
                step = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= REM_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= step && (r_cnt == '0);
            if (load) begin
                r_cnt <= CNT_LAST;
            end else if (step) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (step) begin
            r_dvd <= {r_dvd[WIDTH-2:0], 1'b0};
            r_rem <= rem_next;
        end
    end

    assign o_rem           = r_rem;
    assign o_status.active = (r_state == REM_RUN);
    assign o_status.done   = r_done;

endmodule
